### hdl/olist_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Shared widths, command and status codes and cell control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;
  localparam int DEF_CAPACITY = 64;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_KEY   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_END   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_NOKEY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_LOAD,
    ACT_FROM_LEFT,
    ACT_FROM_RIGHT
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
    logic      cmp;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/olist_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry and its valid flag; compares against the key, loads a new
// value and shifts to or from its neighbours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olist_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire olist_pkg::cell_ctrl_t       ctrl,
  input  wire logic [olist_pkg::DATA_W-1:0] key,
  input  wire logic [olist_pkg::DATA_W-1:0] new_value,
  input  wire logic [olist_pkg::DATA_W-1:0] left_data,
  input  wire logic                        left_valid,
  input  wire logic [olist_pkg::DATA_W-1:0] right_data,
  input  wire logic                        right_valid,
  output logic      [olist_pkg::DATA_W-1:0] data,
  output logic                             valid,
  output logic                             match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        match <= valid && (data == key);
      end
      unique case (ctrl.act)
        olist_pkg::ACT_HOLD:       valid <= valid;
        olist_pkg::ACT_LOAD:       valid <= 1'b1;
        olist_pkg::ACT_FROM_LEFT:  valid <= left_valid;
        olist_pkg::ACT_FROM_RIGHT: valid <= right_valid;
        default:                   valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.act)
      olist_pkg::ACT_HOLD:       data <= data;
      olist_pkg::ACT_LOAD:       data <= new_value;
      olist_pkg::ACT_FROM_LEFT:  data <= left_data;
      olist_pkg::ACT_FROM_RIGHT: data <= right_data;
      default:                   data <= data;
    endcase
  end

endmodule

`default_nettype wire

### hdl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a row of
// cells, with insert and delete at the front, the end or by key.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid / in_stall with operation, value and key.
//   Each request yields one result on out_valid / out_stall carrying status,
//   removed_value and entry_count.
//   An accepted request passes through a compare state, then an apply state;
//   its result is registered when the apply state completes. in_stall is high
//   from the accepting edge until the result is registered, so no new request
//   is taken while one is in progress. This follows from the
//   compare-then-shift sequence of the cell row: every cell compares against
//   the key in the compare state, and the first match picks the cells that
//   shift in the apply state. While the receiver stalls, the result is held
//   and the finished request waits in the apply state; nothing new is taken.
//   Reset empties the list (all cell valid flags clear, count zero) and
//   drops any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine #(
  parameter int CAPACITY = olist_pkg::DEF_CAPACITY,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [olist_pkg::OP_W-1:0]  operation,
  input  wire logic signed [olist_pkg::DATA_W-1:0] value,
  input  wire logic signed [olist_pkg::DATA_W-1:0] key,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [olist_pkg::ST_W-1:0]  status,
  output logic signed      [olist_pkg::DATA_W-1:0] removed_value,
  output logic             [CW-1:0]               entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  state_t state;

  logic [olist_pkg::OP_W-1:0]   op_q;
  logic [olist_pkg::DATA_W-1:0] value_q;
  logic [olist_pkg::DATA_W-1:0] key_q;
  logic [CW-1:0]                count;

  logic [olist_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]          cell_valid;
  logic [CAPACITY-1:0]          cell_match;
  olist_pkg::cell_ctrl_t        cell_ctrl [CAPACITY];

  logic                         in_take;
  logic                         apply_go;
  logic                         full;
  logic                         any_match;
  logic [CAPACITY-1:0]          from_first;
  logic [CAPACITY-1:0]          ge;
  logic [CAPACITY-1:0]          pos_hot;
  logic                         do_ins;
  logic                         do_del;
  logic [olist_pkg::ST_W-1:0]   st;
  logic [olist_pkg::DATA_W-1:0] rem;
  logic [CW-1:0]                count_next;

  assign in_take  = in_valid && !in_stall;
  assign apply_go = (state == S_APPLY) && !(out_valid && out_stall);
  assign full     = (count == CW'(CAPACITY));
  assign any_match  = |cell_match;
  assign from_first = cell_match | (~cell_match + {{(CAPACITY-1){1'b0}}, 1'b1});
  assign pos_hot    = ge & ~{ge[CAPACITY-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q    <= operation;
      value_q <= value;
      key_q   <= key;
    end
  end

  // decide the step from the registered match row
  always_comb begin
    st     = olist_pkg::ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    ge     = '0;
    unique case (op_q)
      olist_pkg::OP_INS_FRONT, olist_pkg::OP_INS_KEY, olist_pkg::OP_INS_END: begin
        if (full) begin
          st = olist_pkg::ST_FULL;
        end else if (op_q == olist_pkg::OP_INS_KEY && !any_match) begin
          st = olist_pkg::ST_NOKEY;
        end else begin
          do_ins = 1'b1;
          if (op_q == olist_pkg::OP_INS_FRONT) begin
            ge = '1;
          end else if (op_q == olist_pkg::OP_INS_END) begin
            ge = ~cell_valid;
          end else begin
            ge = {from_first[CAPACITY-2:0], 1'b0};
          end
        end
      end
      olist_pkg::OP_DEL_FRONT, olist_pkg::OP_DEL_KEY, olist_pkg::OP_DEL_END: begin
        if (count == '0) begin
          st = olist_pkg::ST_EMPTY;
        end else if (op_q == olist_pkg::OP_DEL_KEY && !any_match) begin
          st = olist_pkg::ST_NOKEY;
        end else begin
          do_del = 1'b1;
          if (op_q == olist_pkg::OP_DEL_FRONT) begin
            ge = '1;
          end else if (op_q == olist_pkg::OP_DEL_END) begin
            ge = ~{1'b0, cell_valid[CAPACITY-1:1]};
          end else begin
            ge = from_first;
          end
        end
      end
      default: begin
        st = olist_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    rem = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rem = rem | (cell_data[i] & {olist_pkg::DATA_W{pos_hot[i] & do_del}});
    end
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [olist_pkg::DATA_W-1:0] l_data;
    logic                         l_valid;
    logic [olist_pkg::DATA_W-1:0] r_data;
    logic                         r_valid;

    if (g == 0) begin : g_first
      assign l_data  = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid_l
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
    end

    always_comb begin
      cell_ctrl[g].cmp = (state == S_MATCH);
      cell_ctrl[g].act = olist_pkg::ACT_HOLD;
      if (apply_go && do_ins) begin
        if (pos_hot[g]) begin
          cell_ctrl[g].act = olist_pkg::ACT_LOAD;
        end else if (ge[g]) begin
          cell_ctrl[g].act = olist_pkg::ACT_FROM_LEFT;
        end
      end else if (apply_go && do_del && ge[g]) begin
        cell_ctrl[g].act = olist_pkg::ACT_FROM_RIGHT;
      end
    end

    olist_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl[g]),
      .key         (key_q),
      .new_value   (value_q),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[g]),
      .valid       (cell_valid[g]),
      .match       (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_valid && !out_stall && !apply_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state    <= S_MATCH;
            in_stall <= 1'b1;
          end
        end
        S_MATCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            state         <= S_IDLE;
            in_stall      <= 1'b0;
            out_valid     <= 1'b1;
            status        <= st;
            removed_value <= signed'(rem);
            entry_count   <= count_next;
            count         <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid flags disagree with entry count");

  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
    else $error("valid cells not packed at the head");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_APPLY))
    else $error("result raised outside the apply cycle");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == S_IDLE)
    else $error("request taken while busy");

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives insert, delete and unused-code requests through the valid/stall handshake,
// predicts each result from a queue-based copy of the list, and compares
// status, removed value and entry count on every accepted result. Runs a
// directed opening, then fill, drain and mixed bursts under four idling modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import olist_pkg::*;

  localparam int LIST_CAP       = DEF_CAPACITY;
  localparam int CW             = $clog2(LIST_CAP + 1);
  localparam int RANDOM_ITEMS   = 1950;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_kind_t;

  typedef struct {
    logic        [OP_W-1:0]   op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
    int                       tx_idle;
    int                       rx_idle;
    bit                       drain;
  } list_cmd_t;

  typedef struct {
    logic        [ST_W-1:0]   status;
    logic signed [DATA_W-1:0] removed_value;
    logic        [CW-1:0]     entry_count;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic        [OP_W-1:0]   operation = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic signed [DATA_W-1:0] key = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic        [ST_W-1:0]   status;
  logic signed [DATA_W-1:0] removed_value;
  logic        [CW-1:0]     entry_count;

  list_cmd_t                queued_cmds[$];
  list_result_t             awaited_results[$];
  logic signed [DATA_W-1:0] list_model[$];
  logic signed [DATA_W-1:0] word_pool[6];
  list_cmd_t                cur_cmd;
  int                       rx_stall_pct = 0;
  int                       error_count = 0;
  int                       cmds_accepted = 0;
  int                       results_checked = 0;
  int                       status_seen[4] = '{0, 0, 0, 0};
  int                       quiet_cycles = 0;

  ordered_list_engine #(.CAPACITY(LIST_CAP)) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .value         (value),
    .key           (key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int find_key(logic signed [DATA_W-1:0] k);
    for (int i = 0; i < list_model.size(); i++) begin
      if (list_model[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic list_result_t predict_list_op(list_cmd_t c);
    list_result_t r;
    int           pos;
    r.status        = ST_OK;
    r.removed_value = '0;
    case (c.op)
      OP_INS_FRONT, OP_INS_KEY, OP_INS_END: begin
        if (list_model.size() >= LIST_CAP) begin
          r.status = ST_FULL;
        end else if (c.op == OP_INS_FRONT) begin
          list_model.push_front(c.value);
        end else if (c.op == OP_INS_END) begin
          list_model.push_back(c.value);
        end else begin
          pos = find_key(c.key);
          if (pos < 0) r.status = ST_NOKEY;
          else list_model.insert(pos + 1, c.value);
        end
      end
      OP_DEL_FRONT, OP_DEL_KEY, OP_DEL_END: begin
        if (list_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (c.op == OP_DEL_FRONT) begin
          r.removed_value = list_model.pop_front();
        end else if (c.op == OP_DEL_END) begin
          r.removed_value = list_model.pop_back();
        end else begin
          pos = find_key(c.key);
          if (pos < 0) begin
            r.status = ST_NOKEY;
          end else begin
            r.removed_value = list_model[pos];
            list_model.delete(pos);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = CW'(list_model.size());
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v,
                         logic signed [DATA_W-1:0] k, int tx, int rx, bit drain);
    list_cmd_t c;
    c.op      = op;
    c.value   = v;
    c.key     = k;
    c.tx_idle = tx;
    c.rx_idle = rx;
    c.drain   = drain;
    queued_cmds.push_back(c);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 65) return word_pool[$urandom_range(5)];
    if (r < 72) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(burst_kind_t kind);
    int r;
    r = $urandom_range(99);
    case (kind)
      BURST_FILL: begin
        if (r < 35) return OP_INS_FRONT;
        if (r < 55) return OP_INS_KEY;
        if (r < 90) return OP_INS_END;
        if (r < 94) return OP_DEL_FRONT;
        if (r < 97) return OP_DEL_KEY;
        return OP_DEL_END;
      end
      BURST_DRAIN: begin
        if (r < 5) return OP_INS_FRONT;
        if (r < 10) return OP_INS_KEY;
        if (r < 15) return OP_INS_END;
        if (r < 45) return OP_DEL_FRONT;
        if (r < 70) return OP_DEL_KEY;
        return OP_DEL_END;
      end
      default: begin
        if (r < 2) return OP_SPARE_6;
        if (r < 4) return OP_SPARE_7;
        return OP_W'($urandom_range(5));
      end
    endcase
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_list_op(cur_cmd));
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_cmds.size() != 0
            && !(queued_cmds[0].drain && awaited_results.size() != 0)
            && $urandom_range(99) >= queued_cmds[0].tx_idle) begin
          cur_cmd = queued_cmds.pop_front();
          in_valid     <= 1'b1;
          operation    <= cur_cmd.op;
          value        <= cur_cmd.value;
          key          <= cur_cmd.key;
          rx_stall_pct <= cur_cmd.rx_idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", status);
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          results_checked++;
          if (status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            error_count++;
          end
          if (removed_value !== exp_res.removed_value) begin
            $error("removed_value: expected %0d, actual %0d",
                   exp_res.removed_value, removed_value);
            error_count++;
          end
          if (entry_count !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   exp_res.entry_count, entry_count);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          total;
    int          blk;
    int          len;
    int          tx;
    int          rx;
    burst_kind_t kind;

    // Directed opening: empty-list cases, extremes, duplicates, spare codes
    add_cmd(OP_DEL_FRONT, 0, 0, 0, 0, 0);
    add_cmd(OP_DEL_KEY, 0, 0, 0, 0, 0);
    add_cmd(OP_DEL_END, 0, 0, 0, 0, 0);
    add_cmd(OP_INS_KEY, 1, 0, 0, 0, 0);
    add_cmd(OP_SPARE_6, 32'sh7fff_ffff, -1, 0, 0, 0);
    add_cmd(OP_INS_FRONT, 32'sh8000_0000, 0, 0, 0, 0);
    add_cmd(OP_INS_END, 32'sh7fff_ffff, 0, 0, 0, 0);
    add_cmd(OP_INS_KEY, 0, 32'sh8000_0000, 0, 0, 0);
    add_cmd(OP_INS_KEY, -1, 32'sh7fff_ffff, 0, 0, 0);
    add_cmd(OP_INS_KEY, 3, 12345, 0, 0, 0);
    add_cmd(OP_INS_FRONT, 5, 0, 0, 0, 0);
    add_cmd(OP_INS_END, 5, 0, 0, 0, 0);
    add_cmd(OP_INS_KEY, 9, 5, 0, 0, 0);
    add_cmd(OP_DEL_KEY, 0, 5, 0, 0, 0);
    add_cmd(OP_DEL_KEY, 0, 77, 0, 0, 0);
    add_cmd(OP_SPARE_7, -1, 32'sh8000_0000, 0, 0, 0);
    add_cmd(OP_DEL_FRONT, 0, 0, 0, 0, 0);
    add_cmd(OP_DEL_END, 0, 0, 0, 0, 0);
    add_cmd(OP_DEL_KEY, 0, 32'sh8000_0000, 0, 0, 0);
    add_cmd(OP_DEL_KEY, 0, -1, 0, 0, 0);
    add_cmd(OP_DEL_END, 0, 0, 0, 0, 0);
    add_cmd(OP_DEL_FRONT, 0, 0, 0, 0, 0);
    add_cmd(OP_DEL_FRONT, 0, 0, 0, 0, 0);

    total = 0;
    blk   = 0;
    while (total < RANDOM_ITEMS) begin
      case (blk % 4)
        0: begin tx = 0;  rx = 0;  end
        1: begin tx = 77; rx = 0;  end
        2: begin tx = 0;  rx = 77; end
        default: begin tx = 15; rx = 15; end
      endcase
      case ($urandom_range(3))
        0, 1: kind = BURST_FILL;
        2: kind = BURST_DRAIN;
        default: kind = BURST_MIX;
      endcase
      case (kind)
        BURST_FILL: len = $urandom_range(120, 160);
        BURST_DRAIN: len = $urandom_range(90, 130);
        default: len = $urandom_range(40, 80);
      endcase
      foreach (word_pool[i]) word_pool[i] = $urandom;
      for (int n = 0; n < len && total < RANDOM_ITEMS; n++) begin
        add_cmd(pick_op(kind), pick_word(), pick_word(), tx, rx,
                n == 0 && (blk == 0 || $urandom_range(2) == 0));
        total++;
      end
      blk++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (queued_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d list requests and checked %0d results in %0d bursts",
             cmds_accepted, results_checked, blk);
    $display("Outcomes: %0d ok, %0d empty, %0d key missing, %0d full",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOKEY],
             status_seen[ST_FULL]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/ordered_list_engine.sv
dv/testbench.sv
